// File: hdl/process_id_allocator_top_assert.svh
// Assertion macros for the identifier allocator checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef PROCESS_ID_ALLOCATOR_TOP_ASSERT_SVH
`define PROCESS_ID_ALLOCATOR_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PIDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check an implication that takes effect in the following cycle.
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	`PIDA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/pida_pkg.sv
// Shared constants, types and helpers of the identifier allocator.
// No dependencies.
package pida_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int IDENT_W    = 31;
	localparam int KIND_W     = 2;
	localparam int FREE_W     = 6;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OCCUPY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

	typedef struct packed {
		logic               en;
		logic               occupy;
		logic [SLOT_W-1:0]  idx;
		logic [IDENT_W-1:0] ident;
		logic [IDENT_W-1:0] group;
	} tbl_wr_t;

	typedef struct packed {
		logic               vld;
		logic [IDENT_W-1:0] ident;
		logic [IDENT_W-1:0] group;
	} tbl_rd_t;

	typedef struct packed {
		logic               start;
		logic [IDENT_W-1:0] last_ident;
	} scan_req_t;

	typedef struct packed {
		logic               done;
		logic [IDENT_W-1:0] ident;
		logic               found;
		logic [SLOT_W-1:0]  free_idx;
	} scan_rsp_t;

	function automatic logic [IDENT_W-1:0] next_ident(input logic [IDENT_W-1:0] v);
		logic [IDENT_W-1:0] n;
		n = v + IDENT_W'(1);
		return (n == '0) ? IDENT_W'(1) : n;
	endfunction

endpackage

// File: hdl/pida_table.sv
// Slot table: valid flags in flip-flops, identifier and group memories.
// One write port, one registered read port. Depends on pida_pkg.
module pida_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pida_pkg::tbl_wr_t          wr,
	input  logic [pida_pkg::SLOT_W-1:0] rd_idx,
	output pida_pkg::tbl_rd_t          rd
);

	logic [pida_pkg::SLOT_COUNT-1:0] valid_q;
	logic [pida_pkg::IDENT_W-1:0]    ident_mem [pida_pkg::SLOT_COUNT];
	logic [pida_pkg::IDENT_W-1:0]    group_mem [pida_pkg::SLOT_COUNT];
	logic                            rd_vld_q;
	logic [pida_pkg::IDENT_W-1:0]    rd_ident_q;
	logic [pida_pkg::IDENT_W-1:0]    rd_group_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= wr.occupy;
			end
			rd_vld_q <= valid_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.occupy) begin
			ident_mem[wr.idx] <= wr.ident;
			group_mem[wr.idx] <= wr.group;
		end
		rd_ident_q <= ident_mem[rd_idx];
		rd_group_q <= group_mem[rd_idx];
	end

	assign rd.vld   = rd_vld_q;
	assign rd.ident = rd_ident_q;
	assign rd.group = rd_group_q;

endmodule

// File: hdl/pida_scan.sv
// Collision scan sequencer: walks the slot table once per candidate,
// advances on a match and tracks the lowest free slot above slot 0. Depends on pida_pkg.
module pida_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pida_pkg::scan_req_t         req,
	output logic [pida_pkg::SLOT_W-1:0] rd_idx,
	input  pida_pkg::tbl_rd_t           rd,
	output pida_pkg::scan_rsp_t         rsp
);

	logic                         issue_q;
	logic [pida_pkg::SLOT_W-1:0]  rd_idx_q;
	logic                         pipe_vld_s1;
	logic [pida_pkg::SLOT_W-1:0]  pipe_idx_s1;
	logic [pida_pkg::IDENT_W-1:0] cand_q;
	logic                         free_found_q;
	logic [pida_pkg::SLOT_W-1:0]  free_idx_q;
	logic                         done_q;
	logic                         hit;

	assign hit = pipe_vld_s1 && rd.vld && ((rd.ident == cand_q) || (rd.group == cand_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= 1'b0;
			rd_idx_q     <= '0;
			pipe_vld_s1  <= 1'b0;
			pipe_idx_s1  <= '0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				issue_q      <= 1'b1;
				rd_idx_q     <= '0;
				pipe_vld_s1  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (hit) begin
				issue_q      <= 1'b1;
				rd_idx_q     <= '0;
				pipe_vld_s1  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				pipe_vld_s1 <= issue_q;
				pipe_idx_s1 <= rd_idx_q;
				if (issue_q) begin
					if (rd_idx_q == pida_pkg::SLOT_LAST) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + pida_pkg::SLOT_W'(1);
					end
				end
				if (pipe_vld_s1) begin
					if (!rd.vld && (pipe_idx_s1 != '0) && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (pipe_idx_s1 == pida_pkg::SLOT_LAST) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cand_q <= pida_pkg::next_ident(req.last_ident);
		end else if (hit) begin
			cand_q <= pida_pkg::next_ident(cand_q);
		end
		if (pipe_vld_s1 && !hit && !rd.vld && (pipe_idx_s1 != '0) && !free_found_q) begin
			free_idx_q <= pipe_idx_s1;
		end
	end

	assign rd_idx       = rd_idx_q;
	assign rsp.done     = done_q;
	assign rsp.ident    = cand_q;
	assign rsp.found    = free_found_q;
	assign rsp.free_idx = free_idx_q;

endmodule

// File: hdl/process_id_allocator_top.sv
// Top level of the identifier and slot allocator.
// Depends on pida_pkg, pida_table and pida_scan.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | kind, slot, ident, group_ident
//  out     | out_valid / out_stall| status, new_ident, free_slot
//
// Occupy, release and unused kinds are registered and give their result in the next cycle.
// Allocate reads the table serially, one slot per cycle through the registered memory
// port, walking all slots once per candidate tried, a collision restarting the walk
// early; the scan's done flag and then the result are registered.
// Reset clears all valid flags and the last identifier; no clearing pass is needed.
// in_stall is high during an allocation and while a result waits under out_stall.
module process_id_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pida_pkg::KIND_W-1:0]   kind,
	input  logic [5:0]                    slot,
	input  logic [pida_pkg::IDENT_W-1:0]  ident,
	input  logic [pida_pkg::IDENT_W-1:0]  group_ident,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic [pida_pkg::IDENT_W-1:0]  new_ident,
	output logic [pida_pkg::FREE_W-1:0]   free_slot
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_SCAN = 1'b1;

	logic [0:0]                   state_q;
	logic [pida_pkg::IDENT_W-1:0] last_ident_q;
	logic                         out_valid_q;
	logic                         status_q;
	logic [pida_pkg::IDENT_W-1:0] new_ident_q;
	logic [pida_pkg::FREE_W-1:0]  free_slot_q;
	logic                         accept;
	logic                         res_load;
	logic                         slot_ok;
	logic [pida_pkg::SLOT_W-1:0]  rd_idx;
	pida_pkg::tbl_wr_t            wr;
	pida_pkg::tbl_rd_t            rd;
	pida_pkg::scan_req_t          req;
	pida_pkg::scan_rsp_t          rsp;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign slot_ok  = int'(slot) < pida_pkg::SLOT_COUNT;
	assign res_load = (accept && (kind != pida_pkg::KIND_ALLOC)) ||
	                  ((state_q == ST_SCAN) && rsp.done);

	assign wr.en     = accept && slot_ok &&
	                   ((kind == pida_pkg::KIND_OCCUPY) || (kind == pida_pkg::KIND_RELEASE));
	assign wr.occupy = (kind == pida_pkg::KIND_OCCUPY);
	assign wr.idx    = pida_pkg::SLOT_W'(slot);
	assign wr.ident  = ident;
	assign wr.group  = group_ident;

	assign req.start      = accept && (kind == pida_pkg::KIND_ALLOC);
	assign req.last_ident = last_ident_q;

	pida_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd     (rd)
	);

	pida_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_idx (rd_idx),
		.rd     (rd),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_ident_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == pida_pkg::KIND_ALLOC)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rsp.done) begin
						state_q      <= ST_IDLE;
						last_ident_q <= rsp.ident;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && kind != pida_pkg::KIND_ALLOC) begin
			status_q    <= 1'b0;
			new_ident_q <= '0;
			free_slot_q <= '0;
		end else if (state_q == ST_SCAN && rsp.done) begin
			status_q    <= !rsp.found;
			new_ident_q <= rsp.ident;
			free_slot_q <= rsp.found ? pida_pkg::FREE_W'(rsp.free_idx) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign new_ident = new_ident_q;
	assign free_slot = free_slot_q;

endmodule

// File: hdl/pida_chk.sv
// Port-level checker for the identifier allocator, bound to the top level.
// Depends on pida_pkg and process_id_allocator_top_assert.svh.
`include "process_id_allocator_top_assert.svh"

module pida_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [pida_pkg::KIND_W-1:0]   kind,
	input logic [5:0]                    slot,
	input logic [pida_pkg::IDENT_W-1:0]  ident,
	input logic [pida_pkg::IDENT_W-1:0]  group_ident,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          status,
	input logic [pida_pkg::IDENT_W-1:0]  new_ident,
	input logic [pida_pkg::FREE_W-1:0]   free_slot
);

	`PIDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "transaction dropped under stall")
	`PIDA_ASSERT(a_fail_no_slot, (out_valid && status) |-> (free_slot == '0 && new_ident != '0), "failed allocate reports a slot or zero identifier")
	`PIDA_ASSERT(a_slot_has_ident, (out_valid && free_slot != '0) |-> (new_ident != '0 && !status), "slot given without identifier")
	`PIDA_ASSERT_NEXT(a_alloc_busy, in_valid && !in_stall && kind == pida_pkg::KIND_ALLOC, in_stall && !out_valid, "allocate did not hold off the next transaction")

endmodule

bind process_id_allocator_top pida_chk u_chk (.*);
